// ----- sv/slcan_pkg.sv -----
// ----------------------------------------------------------------------------
// SLCAN encoder package
// Shared types, constants and the hex digit function of the SLCAN encoder.
// ----------------------------------------------------------------------------
package slcan_pkg;

   // One received CAN frame as it arrives on the request channel.
   typedef struct packed {
      logic        is_extended;
      logic        is_remote;
      logic [28:0] can_id;
      logic [3:0]  dlc;
      logic [7:0]  data_byte0;
      logic [7:0]  data_byte1;
      logic [7:0]  data_byte2;
      logic [7:0]  data_byte3;
      logic [7:0]  data_byte4;
      logic [7:0]  data_byte5;
      logic [7:0]  data_byte6;
      logic [7:0]  data_byte7;
   } req_type;

   // One character of the text line.
   typedef struct packed {
      logic [7:0] ascii_char;
      logic       is_last;
   } rsp_type;

   // Classified frame: everything the serialiser needs, already aligned.
   typedef struct packed {
      logic [7:0]  type_char;
      logic [31:0] id_digits;    // first digit to print in bits 31:28
      logic [3:0]  id_count;     // number of identifier digits
      logic [3:0]  dlc;
      logic [4:0]  nibble_count; // payload digits, twice the byte count
      logic [63:0] payload;      // first digit to print in bits 63:60
   } desc_type;

   // Queue status seen by the serialiser.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   localparam int QueueDepth = 2;

   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_DATA    = 8'h74; // 't'
   localparam logic [7:0] CHAR_REMOTE  = 8'h72; // 'r'
   localparam logic [7:0] CASE_OFFSET  = 8'd32;
   localparam logic [7:0] DIGIT_BASE   = 8'h30;
   localparam logic [7:0] LETTER_BASE  = 8'h37;
   localparam logic [3:0] ID_DIGITS_EXT = 4'd8;
   localparam logic [3:0] ID_DIGITS_STD = 4'd3;
   localparam logic [3:0] MAX_BYTES     = 4'd8;

   function automatic logic [7:0] hex_char(input logic [3:0] value);
      logic [7:0] wide;
      wide = {4'h0, value};
      return (value < 4'hA) ? wide + DIGIT_BASE : wide + LETTER_BASE;
   endfunction

endpackage

// ----- sv/slcan_front.sv -----
// ----------------------------------------------------------------------------
// SLCAN encoder front end
// Accepts frames and classifies them into line descriptors for the queue.
// ----------------------------------------------------------------------------
module slcan_front (
   input  logic                req_valid,
   output logic                req_stall,
   input  slcan_pkg::req_type  req_data,
   input  slcan_pkg::q_stat_type q_stat,
   output logic                push,
   output slcan_pkg::desc_type desc
);
   import slcan_pkg::*;

   logic [3:0] byte_count;
   logic [7:0] base_char;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      if (req_data.is_remote) begin
         byte_count = 4'd0;
      end else if (req_data.dlc > MAX_BYTES) begin
         byte_count = MAX_BYTES;
      end else begin
         byte_count = req_data.dlc;
      end

      base_char = req_data.is_remote ? CHAR_REMOTE : CHAR_DATA;
      desc.type_char = req_data.is_extended ? base_char - CASE_OFFSET : base_char;

      if (req_data.is_extended) begin
         desc.id_digits = {3'b000, req_data.can_id};
         desc.id_count  = ID_DIGITS_EXT;
      end else begin
         desc.id_digits = {req_data.can_id[11:0], 20'h00000};
         desc.id_count  = ID_DIGITS_STD;
      end

      desc.dlc          = req_data.dlc;
      desc.nibble_count = {byte_count, 1'b0};
      desc.payload      = {req_data.data_byte0, req_data.data_byte1,
                           req_data.data_byte2, req_data.data_byte3,
                           req_data.data_byte4, req_data.data_byte5,
                           req_data.data_byte6, req_data.data_byte7};
   end

endmodule

// ----- sv/slcan_queue.sv -----
// ----------------------------------------------------------------------------
// SLCAN encoder descriptor queue
// Short first-in first-out queue between the front end and the serialiser.
// ----------------------------------------------------------------------------
module slcan_queue #(
   parameter int DEPTH = slcan_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  slcan_pkg::desc_type   push_desc,
   input  logic                  pop,
   output slcan_pkg::desc_type   head,
   output slcan_pkg::q_stat_type q_stat
);
   import slcan_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   desc_type          slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CntW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ----- sv/slcan_back.sv -----
// ----------------------------------------------------------------------------
// SLCAN encoder serialiser
// Turns one descriptor at a time into its text line, one character a cycle unless stalled.
// ----------------------------------------------------------------------------
module slcan_back (
   input  logic                  clock,
   input  logic                  reset,
   input  slcan_pkg::desc_type   head,
   input  slcan_pkg::q_stat_type q_stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slcan_pkg::rsp_type    rsp_data
);
   import slcan_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ID,
      ST_DLC,
      ST_DATA,
      ST_CR
   } state_type;

   state_type   state_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic [31:0] id_ff;
   logic [63:0] payload_ff;
   logic [3:0]  dlc_ff;
   logic [4:0]  nibbles_ff;
   logic [4:0]  cnt_ff;
   logic        load_in;

   // The output register can take a new character when empty or being taken.
   assign load_in   = !rsp_valid_ff || !rsp_stall;
   assign pop       = load_in && (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else if (load_in) begin
         case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.ascii_char <= head.type_char;
                  rsp_data_ff.is_last    <= 1'b0;
                  id_ff                  <= head.id_digits;
                  cnt_ff                 <= {1'b0, head.id_count};
                  dlc_ff                 <= head.dlc;
                  nibbles_ff             <= head.nibble_count;
                  payload_ff             <= head.payload;
                  state_ff               <= ST_ID;
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_ID: begin
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.ascii_char <= hex_char(id_ff[31:28]);
               rsp_data_ff.is_last    <= 1'b0;
               id_ff                  <= {id_ff[27:0], 4'h0};
               cnt_ff                 <= cnt_ff - 1'b1;
               if (cnt_ff == 5'd1) begin
                  state_ff <= ST_DLC;
               end
            end
            ST_DLC: begin
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.ascii_char <= hex_char(dlc_ff);
               rsp_data_ff.is_last    <= 1'b0;
               cnt_ff                 <= nibbles_ff;
               state_ff               <= (nibbles_ff == '0) ? ST_CR : ST_DATA;
            end
            ST_DATA: begin
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.ascii_char <= hex_char(payload_ff[63:60]);
               rsp_data_ff.is_last    <= 1'b0;
               payload_ff             <= {payload_ff[59:0], 4'h0};
               cnt_ff                 <= cnt_ff - 1'b1;
               if (cnt_ff == 5'd1) begin
                  state_ff <= ST_CR;
               end
            end
            ST_CR: begin
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.ascii_char <= CHAR_CR;
               rsp_data_ff.is_last    <= 1'b1;
               state_ff               <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   // The line end marker only ever rides on a carriage return.
   a_last_is_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_last |-> rsp_data_ff.ascii_char == CHAR_CR)
      else $error("line end marked on a character other than CR");

   // A digit phase never runs with an exhausted counter.
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ID || state_ff == ST_DATA) |-> cnt_ff != '0)
      else $error("digit phase entered with zero count");

   // Taking a descriptor always starts the identifier digits next.
   a_pop_starts_line: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_ID && rsp_valid_ff)
      else $error("descriptor taken without starting a line");

   // A descriptor is only taken when the queue holds one.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("descriptor taken from an empty queue");

endmodule

// ----- sv/can_frame_to_slcan_ascii_core.sv -----
// ----------------------------------------------------------------------------
// CAN frame to SLCAN text encoder
// Accepts received CAN frames and streams out their SLCAN text lines.
// ----------------------------------------------------------------------------
// Usage: one frame is offered on the req_ channel as a single transfer. The
// rsp_ channel then carries its SLCAN line, one ASCII character per transfer:
// the type letter, 3 or 8 identifier digits, the DLC digit, two digits per
// payload byte (none for remote frames, at most eight bytes) and a closing
// carriage return, which alone has is_last set.
// Timing: the frame's descriptor is first written into the queue; once the
// serialiser is idle it loads the line's first character into its output
// register. A line of 6 to 27 characters goes out one character per cycle
// while the receiver does not stall, and when another frame is waiting in
// the queue its line follows the carriage return without a gap.
// The queue holds up to QUEUE_DEPTH classified frames, so a sender can
// hand over frames while a line is still going out; req_stall rises only
// when that queue is full.
// Reset empties the queue, drops any character in the output register and
// returns the serialiser to idle. When the receiver stalls, the current
// character stays unchanged and the serialiser simply waits.
// ----------------------------------------------------------------------------
module can_frame_to_slcan_ascii_core #(
   parameter int QUEUE_DEPTH = slcan_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  slcan_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output slcan_pkg::rsp_type rsp_data
);
   import slcan_pkg::*;

   // Handshake between the front end and the queue.
   logic       push;
   desc_type   push_desc;

   // Handshake between the queue and the serialiser.
   logic       pop;
   desc_type   head;
   q_stat_type q_stat;

   // The front end classifies each frame as it is accepted: it picks the
   // type letter, aligns the identifier for standard or extended printing
   // and works out how many payload digits the line carries.
   slcan_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .desc      (push_desc)
   );

   // The queue decouples acceptance from serialisation so that each side
   // can stall without holding the other.
   slcan_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // The serialiser walks through one line at a time and owns the output
   // register; a waiting character blocks the front end only when the queue is full.
   slcan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
